FILE: hdl/asrcw_pkg.sv
// shared types and constants for the asymmetric raised-cosine weight block
// no dependencies; imported by asymmetric_raised_cosine_weight
package asrcw_pkg;

    // fraction bits of the internal sine and divider arithmetic
    localparam int Q = 30;
    // frame values at or above this limit make the settings invalid
    localparam int unsigned FRAME_LIMIT = 100000;
    // spans shorter than this are flat
    localparam int unsigned MIN_SHAPED_SPAN = 3;

    // configuration register indexes
    localparam logic [1:0] CFG_START = 2'd0;
    localparam logic [1:0] CFG_END   = 2'd1;
    localparam logic [1:0] CFG_PEAK  = 2'd2;
    localparam logic [1:0] CFG_TOTAL = 2'd3;

    // odd polynomial coefficients of sin(pi/2*t), t^1 .. t^13, in Q30
    localparam logic signed [31:0] SIN_COEF [7] = '{
        32'sd1686629713, -32'sd693598669, 32'sd85569306, -32'sd5026995,
        32'sd172272, -32'sd3864, 32'sd61
    };

    // per-item control that travels along the pipeline
    typedef struct packed {
        logic invalid;
        logic beyond;
        logic use_cos;
        logic fixed_one;
    } t_side;

    // divide a Q60 product by 2^30, truncating toward zero
    function automatic logic signed [31:0] trunc_q(input logic signed [63:0] v);
        logic signed [63:0] a;
        a = v + ((v < 0) ? 64'sd1073741823 : 64'sd0);
        return 32'(a >>> Q);
    endfunction

endpackage

FILE: hdl/asymmetric_raised_cosine_weight.sv
// asymmetric raised-cosine window weight, fully pipelined
// depends on asrcw_pkg (constants, coefficients, side-info struct)
//
// Usage: write the four frame registers through the write port while the
// block is idle, then stream frame indexes on the input channel. Each
// transfer yields exactly one result transfer carrying the weight
// (unsigned, WEIGHT_FRAC_BITS fraction bits, one = 2^WEIGHT_FRAC_BITS)
// and the settings_invalid and beyond_length flags.
// The pipeline from input transfer to result valid has one input
// stage, 31 restoring divider stages (one quotient bit each) for d/h in
// Q30, then 17 stages of multiply / truncate-add for the squared sine
// polynomial. One index is accepted per cycle when the output is taken.
// When the receiver stalls a valid result, the whole pipeline holds and
// o_in_stall rises in the same cycle; nothing is lost or repeated.
// Reset clears the pipeline valid bits and loads the registers with
// start 0, end 2, peak 1, total 3.
module asymmetric_raised_cosine_weight
    import asrcw_pkg::*;
#(
    parameter int FRAME_BITS       = 16,
    parameter int WEIGHT_FRAC_BITS = 15
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic [1:0]                  i_cfg_index,
    input  logic [FRAME_BITS-1:0]       i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [FRAME_BITS-1:0]       i_frame_index,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [WEIGHT_FRAC_BITS:0]   o_weight,
    output logic                        o_settings_invalid,
    output logic                        o_beyond_length
);

    localparam int FB = FRAME_BITS;
    localparam int WW = WEIGHT_FRAC_BITS + 1;
    localparam int DQ = Q + 1;          // divider stages, one quotient bit each
    localparam int A  = DQ + 1;         // square stage
    localparam int NS = A + 17;         // total pipeline stages
    localparam logic [WW-1:0] W_ONE = WW'(1) << WEIGHT_FRAC_BITS;
    localparam logic [61:0]   W_RND = 62'(1) << (Q - WEIGHT_FRAC_BITS - 1);

    // configuration registers
    logic [FB-1:0] r_start, r_end, r_peak, r_total;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= FB'(0);
            r_end   <= FB'(2);
            r_peak  <= FB'(1);
            r_total <= FB'(3);
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_START: r_start <= i_cfg_data;
                CFG_END:   r_end   <= i_cfg_data;
                CFG_PEAK:  r_peak  <= i_cfg_data;
                CFG_TOTAL: r_total <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // global advance: hold everything while a result waits on a stall
    logic w_en;
    logic  r_vld [NS];
    t_side r_sd  [NS-1];

    assign w_en        = !(r_vld[NS-1] && i_out_stall);
    assign o_in_stall  = !w_en;
    assign o_out_valid = r_vld[NS-1];

    // input stage decode
    logic          w_invalid, w_beyond, w_inspan, w_small, w_is_end, w_before;
    logic [FB-1:0] w_d, w_h;
    t_side         w_sd;

    always_comb begin
        w_invalid = !(32'(r_start) < FRAME_LIMIT && r_end >= r_start &&
                      32'(r_end) < FRAME_LIMIT && r_peak >= r_start &&
                      r_peak <= r_end && r_total > r_end &&
                      32'(r_total) < FRAME_LIMIT);
        w_beyond  = i_frame_index >= r_total;
        w_inspan  = !w_invalid && !w_beyond &&
                    i_frame_index >= r_start && i_frame_index <= r_end;
        w_small   = 32'(r_end - r_start) + 32'd1 < MIN_SHAPED_SPAN;
        w_is_end  = i_frame_index == r_start || i_frame_index == r_end;
        w_before  = i_frame_index < r_peak;
        w_d       = w_before ? i_frame_index - r_start : r_end - i_frame_index;
        w_h       = w_before ? r_peak - r_start : r_end - r_peak;
        w_sd.invalid   = w_invalid;
        w_sd.beyond    = w_beyond;
        w_sd.use_cos   = w_inspan && !w_small && !w_is_end &&
                         i_frame_index != r_peak;
        w_sd.fixed_one = w_inspan && (w_small ||
                         (!w_is_end && i_frame_index == r_peak));
    end

    // valid and side-info shift line
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NS; k++) r_vld[k] <= 1'b0;
        end else if (w_en) begin
            r_vld[0] <= i_in_valid;
            for (int k = 1; k < NS; k++) r_vld[k] <= r_vld[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sd[0] <= w_sd;
            for (int k = 1; k < NS-1; k++) r_sd[k] <= r_sd[k-1];
        end
    end

    // restoring divider: x = (d*2^30 + h/2) / h, one quotient bit a stage
    logic [FB-1:0] r_rem [DQ+1];
    logic [Q:0]    r_num [DQ+1];
    logic [FB-1:0] r_h   [DQ+1];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_rem[0] <= w_d >> 1;
            r_num[0] <= {w_d[0], Q'(w_h >> 1)};
            r_h[0]   <= w_h;
        end
    end

    for (genvar j = 1; j <= DQ; j++) begin : g_div
        logic [FB:0] w_trial;
        logic        w_ge;
        always_comb begin
            w_trial = {r_rem[j-1], r_num[j-1][Q]};
            w_ge    = w_trial >= {1'b0, r_h[j-1]};
        end
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_rem[j] <= w_ge ? FB'(w_trial - {1'b0, r_h[j-1]}) : FB'(w_trial);
                r_num[j] <= {r_num[j-1][Q-1:0], w_ge};
                r_h[j]   <= r_h[j-1];
            end
        end
    end

    // square: t2 = x*x / 2^30, x carried to the final sine product
    logic [Q:0] r_x  [13];
    logic [Q:0] r_t2 [11];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_x[0]  <= r_num[DQ];
            r_t2[0] <= (Q+1)'((62'(r_num[DQ]) * 62'(r_num[DQ])) >> Q);
            for (int k = 1; k < 13; k++) r_x[k] <= r_x[k-1];
            for (int k = 1; k < 11; k++) r_t2[k] <= r_t2[k-1];
        end
    end

    // horner steps: multiply stage, then truncate and add stage
    logic signed [31:0] r_p    [6];
    logic signed [63:0] r_prod [6];

    for (genvar i = 0; i < 6; i++) begin : g_horner
        logic signed [31:0] w_pin;
        if (i == 0) begin : g_first
            assign w_pin = SIN_COEF[6];
        end else begin : g_next
            assign w_pin = r_p[i-1];
        end
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_prod[i] <= 64'(w_pin) * 64'($signed({1'b0, r_t2[2*i]}));
                r_p[i]    <= SIN_COEF[5-i] + trunc_q(r_prod[i]);
            end
        end
    end

    // sine, clamp, square and round to the weight format
    logic signed [63:0] r_sp;
    logic [Q:0]         r_s;
    logic [61:0]        r_sq;
    logic [WW-1:0]      r_w;
    logic               r_inv, r_bey;
    logic signed [31:0] w_s;
    logic [61:0]        w_r;
    logic [WW-1:0]      w_w;

    always_comb begin
        w_s = trunc_q(r_sp);
        w_r = (r_sq >> Q) + W_RND;
        w_r = w_r >> (Q - WEIGHT_FRAC_BITS);
        if (r_sd[NS-2].invalid || r_sd[NS-2].beyond) begin
            w_w = '0;
        end else if (r_sd[NS-2].use_cos) begin
            w_w = (w_r > 62'(W_ONE)) ? W_ONE : WW'(w_r);
        end else if (r_sd[NS-2].fixed_one) begin
            w_w = W_ONE;
        end else begin
            w_w = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sp <= 64'(r_p[5]) * 64'($signed({1'b0, r_x[12]}));
            if (w_s < 0) begin
                r_s <= '0;
            end else if (w_s > 32'sd1073741824) begin
                r_s <= (Q+1)'(1) << Q;
            end else begin
                r_s <= (Q+1)'(w_s);
            end
            r_sq  <= 62'(r_s) * 62'(r_s);
            r_w   <= w_w;
            r_inv <= r_sd[NS-2].invalid;
            r_bey <= r_sd[NS-2].beyond;
        end
    end

    assign o_weight           = r_w;
    assign o_settings_invalid = r_inv;
    assign o_beyond_length    = r_bey;

    // checks on the pipeline control and result coding
    a_stall_rule: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall == (o_out_valid && i_out_stall))
        else $error("input stall does not follow output hold");

    a_flag_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_settings_invalid || o_beyond_length)) |-> o_weight == '0)
        else $error("flagged result has nonzero weight");

    a_weight_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_weight <= W_ONE)
        else $error("weight above one");

    a_mode_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[0] |-> !(r_sd[0].use_cos && r_sd[0].fixed_one))
        else $error("shaped and flat modes both set");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> $stable(o_weight) && o_out_valid)
        else $error("held result changed");

endmodule

FILE: tb/sv/tb_top.sv
// self-checking testbench for asymmetric_raised_cosine_weight
// depends on asrcw_pkg and the block itself; predicts each weight in fixed point
`timescale 1ns / 1ps

module tb_top
    import asrcw_pkg::*;
();

    localparam int FB = 16;
    localparam int WF = 15;
    localparam int LATENCY = 49;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [WF:0] weight;
        logic        invalid;
        logic        beyond;
    } t_weight_res;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_cfg_wr_en = 1'b0;
    logic [1:0]    i_cfg_index = CFG_START;
    logic [FB-1:0] i_cfg_data = '0;
    logic          i_in_valid = 1'b0;
    logic          o_in_stall;
    logic [FB-1:0] i_frame_index = '0;
    logic          o_out_valid;
    logic          i_out_stall = 1'b0;
    logic [WF:0]   o_weight;
    logic          o_settings_invalid;
    logic          o_beyond_length;

    asymmetric_raised_cosine_weight #(.FRAME_BITS(FB), .WEIGHT_FRAC_BITS(WF)) DUT (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor copy of the frame registers
    logic [FB-1:0] span_start = 0, span_end = 2, span_peak = 1, seq_total = 3;

    logic [FB-1:0] index_queue[$];
    t_weight_res   weight_expect[$];
    int            errors = 0;
    int            idle_cycles = 0;
    bit            driving_done = 0;
    int            sent_count = 0;
    int            recv_count = 0;

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // rising half-cosine for d/h, 0 < d < h
    function automatic logic [WF:0] half_cosine(longint d, longint h);
        longint x, t2, p, s, w, r;
        x = ((d << Q) + (h >> 1)) / h;
        t2 = (x * x) / (longint'(1) << Q);
        p = SIN_COEF[6];
        for (int k = 5; k >= 0; k--)
            p = longint'(SIN_COEF[k]) + (p * t2) / (longint'(1) << Q);
        s = (p * x) / (longint'(1) << Q);
        if (s < 0) s = 0;
        if (s > (longint'(1) << Q)) s = longint'(1) << Q;
        w = (s * s) >>> Q;
        r = (w + (longint'(1) << (Q - WF - 1))) >>> (Q - WF);
        if (r > (longint'(1) << WF)) r = longint'(1) << WF;
        return r[WF:0];
    endfunction

    function automatic t_weight_res window_weight(logic [FB-1:0] idx);
        t_weight_res res;
        longint st, en, pk, tot, ix;
        st = span_start; en = span_end; pk = span_peak; tot = seq_total; ix = idx;
        res = '0;
        res.invalid = !(st < FRAME_LIMIT && en >= st && en < FRAME_LIMIT && pk >= st
                        && pk <= en && tot > en && tot < FRAME_LIMIT);
        res.beyond = ix >= tot;
        if (!res.invalid && !res.beyond && ix >= st && ix <= en) begin
            if (en - st + 1 < MIN_SHAPED_SPAN) res.weight = (WF+1)'(1) << WF;
            else if (ix == st || ix == en) res.weight = '0;
            else if (ix < pk) res.weight = half_cosine(ix - st, pk - st);
            else if (ix > pk) res.weight = half_cosine(en - ix, en - pk);
            else res.weight = (WF+1)'(1) << WF;
        end
        return res;
    endfunction

    // input driver
    int in_gap = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                weight_expect.push_back(window_weight(i_frame_index));
                in_gap = gap_len();
            end
            if (!i_in_valid || !o_in_stall) begin
                if (in_gap > 0) begin
                    in_gap--;
                    i_in_valid <= 1'b0;
                end else if (index_queue.size() > 0) begin
                    i_in_valid <= 1'b1;
                    i_frame_index <= index_queue.pop_front();
                    sent_count++;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and receiver stalls
    int out_gap = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                recv_count++;
                if (weight_expect.size() == 0) begin
                    $display("%0t: unexpected result weight=%0d", $time, o_weight);
                    errors++;
                end else begin
                    t_weight_res e;
                    e = weight_expect.pop_front();
                    if (o_weight !== e.weight) begin
                        $display("%0t: weight expected %0d actual %0d", $time, e.weight, o_weight);
                        errors++;
                    end
                    if (o_settings_invalid !== e.invalid) begin
                        $display("%0t: settings_invalid expected %0b actual %0b",
                                 $time, e.invalid, o_settings_invalid);
                        errors++;
                    end
                    if (o_beyond_length !== e.beyond) begin
                        $display("%0t: beyond_length expected %0b actual %0b",
                                 $time, e.beyond, o_beyond_length);
                        errors++;
                    end
                end
            end
            if (out_gap > 0) begin
                out_gap--;
                i_out_stall <= 1'b1;
            end else begin
                out_gap = gap_len();
                i_out_stall <= 1'b0;
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [FB-1:0] val);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        case (idx)
            CFG_START: span_start = val;
            CFG_END:   span_end = val;
            CFG_PEAK:  span_peak = val;
            default:   seq_total = val;
        endcase
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic set_window(int st, int en, int pk, int tot);
        write_reg(CFG_START, st[FB-1:0]);
        write_reg(CFG_END, en[FB-1:0]);
        write_reg(CFG_PEAK, pk[FB-1:0]);
        write_reg(CFG_TOTAL, tot[FB-1:0]);
    endtask

    // wait until every queued index is sent and every result is back
    task automatic drain();
        while (index_queue.size() > 0 || sent_count != recv_count)
            @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);
    endtask

    // random indexes, mostly inside the span
    task automatic random_batch(int n);
        int lo, hi;
        for (int k = 0; k < n; k++) begin
            lo = span_start;
            hi = span_end;
            if ($urandom_range(0, 9) < 7)
                index_queue.push_back(FB'($urandom_range(lo, hi)));
            else if ($urandom_range(0, 1))
                index_queue.push_back(FB'($urandom_range(0, 65535)));
            else
                index_queue.push_back(FB'(seq_total + $urandom_range(0, 3)));
        end
    endtask

    initial begin
        int st, en, pk;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset settings, a shaped span and beyond-length flags
        index_queue = '{0, 1, 2, 3, 16'hFFFF};
        drain();
        set_window(10, 30, 18, 40);
        index_queue = '{9, 10, 11, 17, 18, 19, 29, 30, 31, 39, 40};
        drain();
        // peak on an end frame and widest span
        set_window(0, 65534, 0, 65535);
        index_queue = '{0, 1, 32767, 65533, 65534, 65535, 16'h5555, 16'hAAAA};
        drain();
        // invalid orderings: peak past end, total at end
        set_window(5, 6, 7, 10);
        index_queue = '{5, 6, 11};
        drain();
        set_window(5, 9, 9, 9);
        index_queue = '{7, 9};
        drain();

        // random phases with varied settings, extremes among them
        for (int ph = 0; ph < 10; ph++) begin
            case (ph)
                0: set_window(0, 2, 1, 3);
                1: set_window(100, 101, 100, 65535);
                2: set_window(0, 65534, 65534, 65535);
                default: begin
                    st = $urandom_range(0, 2000);
                    en = st + $urandom_range(0, 3000);
                    pk = $urandom_range(st, en);
                    set_window(st, en, pk, en + $urandom_range(1, 50));
                end
            endcase
            random_batch(50);
            drain();
        end
        // fully random, mostly invalid settings
        set_window($urandom_range(0, 65535), $urandom_range(0, 65535),
                   $urandom_range(0, 65535), $urandom_range(0, 65535));
        random_batch(30);
        drain();

        if (errors == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

FILE: sim.f
hdl/asrcw_pkg.sv
hdl/asymmetric_raised_cosine_weight.sv
tb/sv/tb_top.sv
